/* design/ordered_list_store_macros.svh */
// Assertion macros for the ordered list store checker.
`ifndef ORDERED_LIST_STORE_MACROS_SVH
`define ORDERED_LIST_STORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered list store check failed");

// Next-cycle implication, disabled during reset.
`define OLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered list store check failed");

`endif

/* design/ols_pkg.sv */
// Types and codes for the ordered list store.
`default_nettype none

package ols_pkg;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_SEARCH = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_INDEX = 2'd2;

  localparam int POS_W   = 4;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] value_in;
  } ols_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [WORD_W-1:0]  read_value;
    logic               found;
    logic [COUNT_W-1:0] count;
  } ols_rsp_t;

  typedef struct packed {
    logic             append_en;
    logic             remove_en;
    logic [POS_W-1:0] pos;
  } ols_ctrl_t;

endpackage

`default_nettype wire

/* design/ols_cell.sv */
// One list slot: holds an entry, loads the word on append, shifts from its neighbor on remove, compares on search.
`default_nettype none

module ols_cell
  import ols_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  wire logic                          clk,
  input  wire ols_ctrl_t                     ctrl,
  input  wire logic [$clog2(DEPTH+1)-1:0]    count,
  input  wire logic [DATA_WIDTH-1:0]         word,
  input  wire logic [DATA_WIDTH-1:0]         nbr_entry,
  output logic      [DATA_WIDTH-1:0]         entry,
  output logic      [DATA_WIDTH-1:0]         rd_entry,
  output logic                               hit
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic held;
  logic append_here;
  logic shift_here;
  logic [DATA_WIDTH-1:0] entry_next;

  assign held        = CW'(INDEX) < count;
  assign append_here = ctrl.append_en && (CW'(INDEX) == count);
  assign shift_here  = ctrl.remove_en && (PW'(INDEX) >= PW'(ctrl.pos)) &&
                       (CW'(INDEX + 1) < count);

  always_comb begin
    entry_next = entry;
    if (append_here) begin
      entry_next = word;
    end else if (shift_here) begin
      entry_next = nbr_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign rd_entry = (PW'(INDEX) == PW'(ctrl.pos)) ? entry : '0;
  assign hit      = held && (entry == word);

endmodule

`default_nettype wire

/* design/ordered_list_store.sv */
// Top level of the ordered list store: a row of entry cells with count and result logic.
// The result strobe (done) rises in the cycle after a request beat is accepted.
// Throughput: one request per cycle while busy is low; every cell compares and shifts in parallel.
// Reset: synchronous; count clears to zero, busy is set in reset and clears at the first clock without reset.
// Entries carry no reset; only slots below the count are ever read.
// The receiver cannot stall: done is high for a single cycle per result; rsp holds until the next accepted request.
`default_nettype none

module ordered_list_store
  import ols_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire ols_req_t req,
  output logic          done,
  output ols_rsp_t      rsp
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          pos_bad;
  logic [DATA_WIDTH-1:0] word;
  ols_ctrl_t     ctrl;
  ols_rsp_t      rsp_next;

  logic [DATA_WIDTH-1:0] chain   [DEPTH+1];
  logic [DATA_WIDTH-1:0] rd_part [DEPTH];
  logic [DEPTH-1:0]      hits;
  logic [DATA_WIDTH-1:0] rd_sel;
  logic [63:0]           rd_wide;

  assign accept  = start && !busy;
  assign word    = DATA_WIDTH'(req.value_in);
  assign full    = count == CW'(DEPTH);
  assign pos_bad = PW'(req.position) >= PW'(count);

  assign ctrl.append_en = accept && (req.req_type == REQ_APPEND) && !full;
  assign ctrl.remove_en = accept && (req.req_type == REQ_REMOVE) && !pos_bad;
  assign ctrl.pos       = req.position;

  assign chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ols_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .word      (word),
      .nbr_entry (chain[i+1]),
      .entry     (chain[i]),
      .rd_entry  (rd_part[i]),
      .hit       (hits[i])
    );
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_sel = rd_sel | rd_part[i];
    end
  end

  assign rd_wide = 64'(rd_sel);

  always_comb begin
    count_next          = count;
    rsp_next.status     = ST_DONE;
    rsp_next.read_value = '0;
    rsp_next.found      = 1'b0;
    unique case (req.req_type)
      REQ_APPEND: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      REQ_REMOVE: begin
        if (pos_bad) begin
          rsp_next.status = ST_INDEX;
        end else begin
          count_next = count - CW'(1);
        end
      end
      REQ_READ: begin
        if (pos_bad) begin
          rsp_next.status = ST_INDEX;
        end else begin
          rsp_next.read_value = rd_wide[WORD_W-1:0];
        end
      end
      default: begin
        rsp_next.found = |hits;
      end
    endcase
    rsp_next.count = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      busy <= 1'b0;
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

/* design/ols_checker.sv */
// Port-level checks for the ordered list store, bound to the top level.
`default_nettype none
`include "ordered_list_store_macros.svh"

module ols_checker
  import ols_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input wire ols_rsp_t rsp
);

  `OLS_ASSERT_NEXT(a_beat_gives_result, start && !busy, done)
  `OLS_ASSERT_NEXT(a_no_beat_no_result, !(start && !busy), !done)
  `OLS_ASSERT_SAME(a_full_count, done && (rsp.status == ST_FULL), rsp.count == COUNT_W'(DEPTH))
  `OLS_ASSERT_SAME(a_refused_clean, done && (rsp.status != ST_DONE),
                   (rsp.read_value == '0) && !rsp.found)

endmodule

bind ordered_list_store ols_checker #(.DEPTH(DEPTH)) u_ols_checker (.*);

`default_nettype wire
